>>> sv/ngfp_pkg.sv
// shared types, codes and constants of the nmea gga/gsv field parser
`default_nettype none
package ngfp_pkg;

  localparam int unsigned QUEUE_DEPTH = 2;
  localparam int unsigned VALUE_W     = 40;

  localparam logic [7:0] CHR_DOLLAR = 8'h24;
  localparam logic [7:0] CHR_COMMA  = 8'h2C;
  localparam logic [7:0] CHR_STAR   = 8'h2A;
  localparam logic [7:0] CHR_G      = 8'h47;
  localparam logic [7:0] CHR_P      = 8'h50;
  localparam logic [7:0] CHR_A      = 8'h41;
  localparam logic [7:0] CHR_S      = 8'h53;
  localparam logic [7:0] CHR_V      = 8'h56;
  localparam logic [7:0] CHR_ONE    = 8'h31;
  localparam logic [7:0] CHR_DOT    = 8'h2E;
  localparam logic [7:0] CHR_ZERO   = 8'h30;
  localparam logic [7:0] CHR_NINE   = 8'h39;

  localparam logic [3:0] CODE_DOT = 4'd10;

  localparam logic [1:0] END_GGA = 2'h1;
  localparam logic [1:0] END_GSV = 2'h2;

  typedef enum logic [1:0] {
    MODE_IDLE   = 2'd0,
    MODE_HEADER = 2'd1,
    MODE_BODY   = 2'd2
  } mode_e;

  typedef enum logic [1:0] {
    STYPE_NONE = 2'd0,
    STYPE_GGA  = 2'd1,
    STYPE_GSV  = 2'd2
  } stype_e;

  typedef enum logic [2:0] {
    CLS_DOLLAR = 3'd0,
    CLS_COMMA  = 3'd1,
    CLS_STAR   = 3'd2,
    CLS_DIGIT  = 3'd3,
    CLS_DOT    = 3'd4,
    CLS_OTHER  = 3'd5
  } class_e;

  typedef enum logic [2:0] {
    KIND_TIME     = 3'd0,
    KIND_LAT      = 3'd1,
    KIND_LON      = 3'd2,
    KIND_SAT_USED = 3'd3,
    KIND_SAT_VIEW = 3'd4,
    KIND_END      = 3'd5
  } kind_e;

  typedef struct packed {
    logic       command;
    logic [7:0] rx_byte;
  } in_item_t;

  typedef struct packed {
    logic [2:0]         field_kind;
    logic [VALUE_W-1:0] field_value;
    logic               fix_valid;
    logic               signal_ok;
    logic [1:0]         sentence_mask;
    logic               position_hold;
  } out_item_t;

  // classified item as it sits in the queue
  typedef struct packed {
    logic       ack;
    class_e     cls;
    logic [3:0] code;
    logic       is_one;
    logic [7:0] chr;
  } entry_t;

  // queue head as seen by the back end
  typedef struct packed {
    logic   valid;
    entry_t entry;
  } head_t;

endpackage
`default_nettype wire

>>> sv/ngfp_front.sv
// front end: classifies each received item and hands it to the queue
`default_nettype none
module ngfp_front
  import ngfp_pkg::*;
(
  input  wire logic     in_valid_i,
  input  wire in_item_t in_data_i,
  output logic          push_o,
  output entry_t        entry_o
);

  logic [7:0] c;

  assign c      = in_data_i.rx_byte;
  assign push_o = in_valid_i;

  always_comb begin
    entry_o        = '0;
    entry_o.ack    = in_data_i.command;
    entry_o.chr    = c;
    entry_o.is_one = (c == CHR_ONE);
    entry_o.code   = 4'd0;
    if (c == CHR_DOLLAR) begin
      entry_o.cls = CLS_DOLLAR;
    end else if (c == CHR_COMMA) begin
      entry_o.cls = CLS_COMMA;
    end else if (c == CHR_STAR) begin
      entry_o.cls = CLS_STAR;
    end else if (c >= CHR_ZERO && c <= CHR_NINE) begin
      entry_o.cls  = CLS_DIGIT;
      entry_o.code = 4'(c - CHR_ZERO);
    end else if (c == CHR_DOT) begin
      entry_o.cls  = CLS_DOT;
      entry_o.code = CODE_DOT;
    end else begin
      entry_o.cls = CLS_OTHER;
    end
  end

endmodule
`default_nettype wire

>>> sv/ngfp_queue.sv
// short queue between the classifying front end and the parsing back end
`default_nettype none
module ngfp_queue
  import ngfp_pkg::*;
#(
  parameter int unsigned Depth = QUEUE_DEPTH
) (
  input  wire logic   clk_i,
  input  wire logic   rst_ni,
  input  wire logic   push_i,
  input  wire entry_t entry_i,
  output logic        full_o,
  input  wire logic   pop_i,
  output head_t       head_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(Depth - 1);
  localparam logic [CntW-1:0] FullCnt = CntW'(Depth);

  entry_t          slot_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] count_q, count_d;
  logic            do_push, do_pop;

  assign full_o       = (count_q == FullCnt);
  assign do_push      = push_i && !full_o;
  assign do_pop       = pop_i && (count_q != '0);
  assign head_o.valid = (count_q != '0);
  assign head_o.entry = slot_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == LastPtr) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == LastPtr) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_d = count_q + 1'b1;
    end else if (do_pop && !do_push) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      slot_q[wr_ptr_q] <= entry_i;
    end
  end

endmodule
`default_nettype wire

>>> sv/ngfp_back.sv
// back end: sentence state machine, digit stores and the output register
`default_nettype none
module ngfp_back
  import ngfp_pkg::*;
(
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  input  wire head_t head_i,
  output logic       pop_o,
  output logic       out_valid_o,
  output out_item_t  out_data_o,
  input  wire logic  out_stall_i
);

  mode_e      mode_q, mode_d;
  stype_e     stype_q, stype_d;
  logic [7:0] field_q, field_d;
  logic [7:0] ci_q, ci_d;
  logic [7:0] hdr_q [4];
  logic [7:0] hdr_d [4];
  logic [3:0] time_q [6];
  logic [3:0] time_d [6];
  logic [3:0] lat_q [9];
  logic [3:0] lat_d [9];
  logic [3:0] lon_q [10];
  logic [3:0] lon_d [10];
  logic [3:0] used_q [2];
  logic [3:0] used_d [2];
  logic [3:0] view_q [2];
  logic [3:0] view_d [2];
  logic       fix_q, fix_d;
  logic       hold_q, hold_d;
  logic [1:0] ended_q, ended_d;
  logic       signal_q, signal_d;

  logic       out_valid_q, out_valid_d;
  out_item_t  out_q, out_d;

  entry_t     e;
  logic       ready, take, is_ack, is_chr, plain;
  logic       hdr_last, gga_act, gsv_act, used_done, view_done;
  logic       code_ok, digit_ok;
  stype_e     hdr_kind;
  logic       emit;
  kind_e      emit_kind;
  logic [VALUE_W-1:0] emit_value;

  assign e      = head_i.entry;
  assign ready  = !out_valid_q || !out_stall_i;
  assign take   = head_i.valid && ready;
  assign pop_o  = take;
  assign is_ack = take && e.ack;
  assign is_chr = take && !e.ack;
  assign plain  = is_chr && (e.cls == CLS_DIGIT || e.cls == CLS_DOT || e.cls == CLS_OTHER);

  assign code_ok  = (e.cls == CLS_DIGIT) || (e.cls == CLS_DOT);
  assign digit_ok = (e.cls == CLS_DIGIT);

  // sentence type from the four stored header characters and the fifth, the current one
  always_comb begin
    hdr_kind = STYPE_NONE;
    if (hdr_q[0] == CHR_G && hdr_q[1] == CHR_P && hdr_q[2] == CHR_G) begin
      if (hdr_q[3] == CHR_G && e.chr == CHR_A) begin
        hdr_kind = STYPE_GGA;
      end else if (hdr_q[3] == CHR_S && e.chr == CHR_V) begin
        hdr_kind = STYPE_GSV;
      end
    end
  end

  assign hdr_last  = plain && (mode_q == MODE_HEADER) && (ci_q == 8'd4);
  assign gga_act   = plain && (mode_q == MODE_BODY) && (stype_q == STYPE_GGA) && !hold_q;
  assign gsv_act   = plain && (mode_q == MODE_BODY) && (stype_q == STYPE_GSV) &&
                     (field_q == 8'd3);
  assign used_done = gga_act && (field_q == 8'd7) && (ci_q == 8'd1);
  assign view_done = gsv_act && (ci_q == 8'd1);

  // next parse mode
  always_comb begin
    mode_d = mode_q;
    priority if (is_chr && e.cls == CLS_DOLLAR) begin
      mode_d = MODE_HEADER;
    end else if (is_chr && e.cls == CLS_STAR) begin
      mode_d = MODE_IDLE;
    end else if (hdr_last) begin
      mode_d = (hdr_kind != STYPE_NONE) ? MODE_BODY : MODE_IDLE;
    end else if (used_done || view_done) begin
      mode_d = MODE_IDLE;
    end
  end

  // stores, counters and flags
  always_comb begin
    stype_d    = stype_q;
    field_d    = field_q;
    ci_d       = ci_q;
    hdr_d      = hdr_q;
    time_d     = time_q;
    lat_d      = lat_q;
    lon_d      = lon_q;
    used_d     = used_q;
    view_d     = view_q;
    fix_d      = fix_q;
    hold_d     = hold_q;
    ended_d    = ended_q;
    signal_d   = signal_q;
    emit       = 1'b0;
    emit_kind  = KIND_END;
    emit_value = '0;

    if (is_ack) begin
      hold_d  = 1'b0;
      ended_d = 2'b00;
    end else if (is_chr) begin
      unique case (e.cls)
        CLS_DOLLAR: begin
          stype_d = STYPE_NONE;
          ci_d    = 8'd0;
        end
        CLS_COMMA: begin
          if (field_q != 8'hFF) begin
            field_d = field_q + 8'd1;
          end
          ci_d = 8'd0;
        end
        CLS_STAR: begin
          if (stype_q == STYPE_GGA) begin
            ended_d = ended_q | END_GGA;
            emit    = 1'b1;
          end else if (stype_q == STYPE_GSV) begin
            ended_d = ended_q | END_GSV;
            emit    = 1'b1;
          end
        end
        CLS_DIGIT, CLS_DOT, CLS_OTHER: begin
          if (ci_q != 8'hFF) begin
            ci_d = ci_q + 8'd1;
          end
          if (mode_q == MODE_HEADER) begin
            if (ci_q < 8'd4) begin
              hdr_d[ci_q[1:0]] = e.chr;
            end
            if (hdr_last && hdr_kind != STYPE_NONE) begin
              stype_d = hdr_kind;
              field_d = 8'd0;
              ci_d    = 8'd0;
            end
          end
          if (gga_act) begin
            unique case (field_q)
              8'd1: begin
                if (ci_q < 8'd6 && code_ok) time_d[ci_q[2:0]] = e.code;
                if (ci_q == 8'd5) begin
                  emit      = 1'b1;
                  emit_kind = KIND_TIME;
                  for (int i = 0; i < 6; i++) emit_value[4*(5-i) +: 4] = time_d[i];
                end
              end
              8'd2: begin
                if (ci_q < 8'd9 && code_ok) lat_d[ci_q[3:0]] = e.code;
                if (ci_q == 8'd8) begin
                  emit      = 1'b1;
                  emit_kind = KIND_LAT;
                  for (int i = 0; i < 9; i++) emit_value[4*(8-i) +: 4] = lat_d[i];
                end
              end
              8'd4: begin
                if (ci_q < 8'd10 && code_ok) lon_d[ci_q[3:0]] = e.code;
                if (ci_q == 8'd9) begin
                  emit      = 1'b1;
                  emit_kind = KIND_LON;
                  for (int i = 0; i < 10; i++) emit_value[4*(9-i) +: 4] = lon_d[i];
                end
              end
              8'd6: begin
                if (ci_q == 8'd0) fix_d = e.is_one;
              end
              8'd7: begin
                if (ci_q < 8'd2 && digit_ok) used_d[ci_q[0]] = e.code;
                signal_d = fix_q;
                if (used_done) begin
                  hold_d     = 1'b1;
                  emit       = 1'b1;
                  emit_kind  = KIND_SAT_USED;
                  emit_value = {{(VALUE_W-8){1'b0}}, used_d[0], used_d[1]};
                end
              end
              default: ;
            endcase
          end
          if (gsv_act) begin
            if (ci_q < 8'd2 && digit_ok) view_d[ci_q[0]] = e.code;
            if (view_done) begin
              emit       = 1'b1;
              emit_kind  = KIND_SAT_VIEW;
              emit_value = {{(VALUE_W-8){1'b0}}, view_d[0], view_d[1]};
            end
          end
        end
        default: ;
      endcase
    end
  end

  // output register: refilled whenever it is empty or being transferred
  always_comb begin
    out_valid_d = out_valid_q;
    out_d       = out_q;
    if (ready) begin
      out_valid_d = take && emit;
    end
    if (take && emit) begin
      out_d.field_kind    = emit_kind;
      out_d.field_value   = emit_value;
      out_d.fix_valid     = fix_d;
      out_d.signal_ok     = signal_d;
      out_d.sentence_mask = ended_d;
      out_d.position_hold = hold_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q      <= MODE_IDLE;
      stype_q     <= STYPE_NONE;
      field_q     <= '0;
      ci_q        <= '0;
      hdr_q       <= '{default: '0};
      time_q      <= '{default: '0};
      lat_q       <= '{default: '0};
      lon_q       <= '{default: '0};
      used_q      <= '{default: '0};
      view_q      <= '{default: '0};
      fix_q       <= 1'b0;
      hold_q      <= 1'b0;
      ended_q     <= '0;
      signal_q    <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      mode_q      <= mode_d;
      stype_q     <= stype_d;
      field_q     <= field_d;
      ci_q        <= ci_d;
      hdr_q       <= hdr_d;
      time_q      <= time_d;
      lat_q       <= lat_d;
      lon_q       <= lon_d;
      used_q      <= used_d;
      view_q      <= view_d;
      fix_q       <= fix_d;
      hold_q      <= hold_d;
      ended_q     <= ended_d;
      signal_q    <= signal_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q <= out_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

`ifndef SYNTHESIS
  a_body_has_type: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mode_q == MODE_BODY |-> stype_q != STYPE_NONE)
    else $error("body mode without a sentence type");

  a_used_sets_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    used_done |=> hold_q && out_valid_q && out_q.field_kind == KIND_SAT_USED)
    else $error("satellites-used result without hold");

  a_kind_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> out_q.field_kind <= KIND_END)
    else $error("result kind out of range");

  a_no_take_when_blocked: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_stall_i) |-> !pop_o)
    else $error("queue popped while output register is blocked");
`endif

endmodule
`default_nettype wire

>>> sv/nmea_gga_gsv_field_parser.sv
// top level of the nmea gga/gsv field parser
//
//   port group   dir  payload      handshake
//   in_*         in   in_item_t    in_valid_i / in_stall_o
//   out_*        out  out_item_t   out_valid_o / out_stall_i
//
// one item per cycle sustained while the output is not stalled; a result is registered
// first in a queue slot at its transfer edge, then in the output register
// in_stall_o is high only while the queue is full
// a stalled output holds its register and the queue keeps taking items until full
// reset clears all parser state, the queue and the output valid flag, not the output data
`default_nettype none
module nmea_gga_gsv_field_parser
  import ngfp_pkg::*;
#(
  parameter int unsigned QueueDepth = QUEUE_DEPTH
) (
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire logic      in_valid_i,
  input  wire in_item_t  in_data_i,
  output logic           in_stall_o,
  output logic           out_valid_o,
  output out_item_t      out_data_o,
  input  wire logic      out_stall_i
);

  logic   push, pop, full;
  entry_t entry;
  head_t  head;

  ngfp_front u_front (
    .in_valid_i (in_valid_i),
    .in_data_i  (in_data_i),
    .push_o     (push),
    .entry_o    (entry)
  );

  ngfp_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .entry_i (entry),
    .full_o  (full),
    .pop_i   (pop),
    .head_o  (head)
  );

  ngfp_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .head_i      (head),
    .pop_o       (pop),
    .out_valid_o (out_valid_o),
    .out_data_o  (out_data_o),
    .out_stall_i (out_stall_i)
  );

  assign in_stall_o = full;

endmodule
`default_nettype wire

>>> tb/testbench.sv
// testbench of the nmea gga/gsv field parser: random sentences, checked against a predictor
`timescale 1ns / 1ps
module testbench;
  import ngfp_pkg::*;

  localparam int unsigned WATCHDOG_LIMIT = 2000;
  localparam int unsigned DRAIN_CYCLES   = 10;
  localparam int unsigned MAX_REPORTS    = 10;

  // field positions within a sentence
  localparam logic [7:0] FLD_GGA_TIME = 8'd1;
  localparam logic [7:0] FLD_GGA_LAT  = 8'd2;
  localparam logic [7:0] FLD_GGA_LON  = 8'd4;
  localparam logic [7:0] FLD_GGA_FIX  = 8'd6;
  localparam logic [7:0] FLD_GGA_SATS = 8'd7;
  localparam logic [7:0] FLD_GSV_SATS = 8'd3;
  localparam logic [7:0] IDX_MAX      = 8'hFF;

  localparam logic [7:0] CHR_CR = 8'h0D;
  localparam logic [7:0] CHR_LF = 8'h0A;

  typedef logic [3:0] nib_arr_t [10];

  logic      clk_i = 1'b0;
  logic      rst_ni = 1'b0;
  logic      in_valid_i = 1'b0;
  in_item_t  in_data_i = '0;
  logic      in_stall_o;
  logic      out_valid_o;
  out_item_t out_data_o;
  logic      out_stall_i = 1'b0;

  nmea_gga_gsv_field_parser dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_data_i  (in_data_i),
    .in_stall_o (in_stall_o),
    .out_valid_o(out_valid_o),
    .out_data_o (out_data_o),
    .out_stall_i(out_stall_i)
  );

  always #5 clk_i = ~clk_i;

  in_item_t  rx_pending[$];
  out_item_t fields_due[$];

  // predictor state
  mode_e      psr_mode;
  stype_e     psr_stype;
  logic [7:0] fld_idx;
  logic [7:0] chr_idx;
  logic [7:0] hdr_chars [5];
  nib_arr_t   time_codes;
  nib_arr_t   lat_codes;
  nib_arr_t   lon_codes;
  nib_arr_t   used_codes;
  nib_arr_t   view_codes;
  logic [7:0] fix_chr;
  logic       hold_flag;
  logic [1:0] ended_mask;
  logic       signal_flag;

  int unsigned mismatches = 0;
  int unsigned idle_cycles = 0;
  int          gap_left = 0;
  int          in_calm = 0;
  int          stall_left = 0;
  int          out_calm = 0;
  logic        in_fire = 1'b0;
  bit          field_made;
  out_item_t   field_pred;
  out_item_t   field_want;

  function automatic logic [3:0] next_code(input logic [3:0] old, input logic [7:0] c,
                                           input bit dot_ok);
    logic [7:0] d;
    d = c - CHR_ZERO;
    if (c >= CHR_ZERO && c <= CHR_NINE) return d[3:0];
    if (dot_ok && c == CHR_DOT) return CODE_DOT;
    return old;
  endfunction

  function automatic logic [VALUE_W-1:0] pack_codes(input nib_arr_t d, input int n);
    logic [VALUE_W-1:0] v;
    v = '0;
    for (int i = 0; i < n; i++) v = {v[VALUE_W-5:0], d[i]};
    return v;
  endfunction

  task automatic parse_nmea_char(input in_item_t it, output bit got, output out_item_t res);
    logic [7:0]         c;
    logic [7:0]         ci;
    kind_e              kind;
    logic [VALUE_W-1:0] val;
    c = it.rx_byte;
    ci = chr_idx;
    got = 1'b0;
    kind = KIND_TIME;
    val = '0;
    if (it.command) begin
      hold_flag = 1'b0;
      ended_mask = '0;
    end else if (c == CHR_DOLLAR) begin
      psr_stype = STYPE_NONE;
      psr_mode = MODE_HEADER;
      chr_idx = '0;
    end else if (c == CHR_COMMA) begin
      if (fld_idx != IDX_MAX) fld_idx++;
      chr_idx = '0;
    end else if (c == CHR_STAR) begin
      psr_mode = MODE_IDLE;
      if (psr_stype == STYPE_GGA || psr_stype == STYPE_GSV) begin
        ended_mask |= (psr_stype == STYPE_GGA) ? END_GGA : END_GSV;
        got = 1'b1;
        kind = KIND_END;
      end
    end else begin
      if (psr_mode == MODE_HEADER) begin
        if (ci < 5) hdr_chars[ci] = c;
        if (ci >= 4) begin
          if (hdr_chars[0] == CHR_G && hdr_chars[1] == CHR_P && hdr_chars[2] == CHR_G &&
              ((hdr_chars[3] == CHR_G && hdr_chars[4] == CHR_A) ||
               (hdr_chars[3] == CHR_S && hdr_chars[4] == CHR_V))) begin
            psr_stype = (hdr_chars[3] == CHR_G) ? STYPE_GGA : STYPE_GSV;
            psr_mode = MODE_BODY;
            fld_idx = '0;
            chr_idx = '0;
          end else begin
            psr_mode = MODE_IDLE;
          end
        end
      end else if (psr_mode == MODE_BODY) begin
        if (psr_stype == STYPE_GGA && !hold_flag) begin
          case (fld_idx)
            FLD_GGA_TIME: begin
              if (ci < 6) time_codes[ci] = next_code(time_codes[ci], c, 1'b1);
              if (ci == 5) begin
                got = 1'b1;
                kind = KIND_TIME;
                val = pack_codes(time_codes, 6);
              end
            end
            FLD_GGA_LAT: begin
              if (ci < 9) lat_codes[ci] = next_code(lat_codes[ci], c, 1'b1);
              if (ci == 8) begin
                got = 1'b1;
                kind = KIND_LAT;
                val = pack_codes(lat_codes, 9);
              end
            end
            FLD_GGA_LON: begin
              if (ci < 10) lon_codes[ci] = next_code(lon_codes[ci], c, 1'b1);
              if (ci == 9) begin
                got = 1'b1;
                kind = KIND_LON;
                val = pack_codes(lon_codes, 10);
              end
            end
            FLD_GGA_FIX: begin
              if (ci == 0) fix_chr = c;
            end
            FLD_GGA_SATS: begin
              if (ci < 2) used_codes[ci] = next_code(used_codes[ci], c, 1'b0);
              signal_flag = (fix_chr == CHR_ONE);
              if (ci == 1) begin
                hold_flag = 1'b1;
                psr_mode = MODE_IDLE;
                got = 1'b1;
                kind = KIND_SAT_USED;
                val = pack_codes(used_codes, 2);
              end
            end
            default: ;
          endcase
        end else if (psr_stype == STYPE_GSV && fld_idx == FLD_GSV_SATS) begin
          if (ci < 2) view_codes[ci] = next_code(view_codes[ci], c, 1'b0);
          if (ci == 1) begin
            psr_mode = MODE_IDLE;
            got = 1'b1;
            kind = KIND_SAT_VIEW;
            val = pack_codes(view_codes, 2);
          end
        end
      end
      if (chr_idx != IDX_MAX) chr_idx++;
    end
    res.field_kind    = kind;
    res.field_value   = val;
    res.fix_valid     = (fix_chr == CHR_ONE);
    res.signal_ok     = signal_flag;
    res.sentence_mask = ended_mask;
    res.position_hold = hold_flag;
  endtask

  // ---- stimulus building ----

  task automatic add_byte(input logic [7:0] b);
    rx_pending.push_back('{command: 1'b0, rx_byte: b});
  endtask

  task automatic add_ack(input logic [7:0] b);
    rx_pending.push_back('{command: 1'b1, rx_byte: b});
  endtask

  task automatic add_text(input string s);
    for (int i = 0; i < s.len(); i++) add_byte(s[i]);
  endtask

  task automatic add_pick(input string s);
    add_byte(s[$urandom_range(0, s.len() - 1)]);
  endtask

  // mostly digits, some dots, a few arbitrary bytes that are not delimiters
  function automatic logic [7:0] field_char();
    int unsigned r;
    logic [7:0]  b;
    r = $urandom_range(0, 99);
    if (r < 78) return CHR_ZERO + 8'($urandom_range(0, 9));
    if (r < 88) return CHR_DOT;
    do b = 8'($urandom_range(0, 255));
    while (b == CHR_DOLLAR || b == CHR_COMMA || b == CHR_STAR);
    return b;
  endfunction

  task automatic add_field(input int n);
    repeat (n) add_byte(field_char());
  endtask

  function automatic int vary(input int n);
    if ($urandom_range(0, 99) < 85) return n;
    return $urandom_range(0, n + 2);
  endfunction

  task automatic add_header(input string hdr);
    int         pos;
    bit         spoil;
    logic [7:0] b;
    spoil = ($urandom_range(0, 9) == 0);
    pos = $urandom_range(0, 4);
    add_byte(CHR_DOLLAR);
    for (int i = 0; i < 5; i++) begin
      b = hdr[i];
      if (spoil && i == pos) b = 8'($urandom_range(0, 255));
      add_byte(b);
    end
  endtask

  // trailing fields, then usually a proper end with checksum and line break
  task automatic add_tail();
    repeat ($urandom_range(0, 6)) begin
      add_byte(CHR_COMMA);
      add_field($urandom_range(0, 5));
    end
    if ($urandom_range(0, 9) != 0) begin
      add_byte(CHR_STAR);
      add_pick("0123456789ABCDEF");
      add_pick("0123456789ABCDEF");
      add_byte(CHR_CR);
      add_byte(CHR_LF);
    end
  endtask

  task automatic add_gga();
    add_header("GPGGA");
    add_byte(CHR_COMMA);
    add_field(vary(6));
    add_byte(CHR_COMMA);
    add_field(vary(9));
    add_byte(CHR_COMMA);
    add_pick("NS");
    add_byte(CHR_COMMA);
    add_field(vary(10));
    add_byte(CHR_COMMA);
    add_pick("EW");
    add_byte(CHR_COMMA);
    case ($urandom_range(0, 3))
      0:       add_pick("02");
      3:       add_byte(field_char());
      default: add_byte(CHR_ONE);
    endcase
    if ($urandom_range(0, 9) == 0) add_field($urandom_range(1, 2));
    add_byte(CHR_COMMA);
    add_field(vary(2));
    add_tail();
    if ($urandom_range(0, 9) < 7) add_ack(8'($urandom_range(0, 255)));
  endtask

  task automatic add_gsv();
    add_header("GPGSV");
    add_byte(CHR_COMMA);
    add_field(vary(1));
    add_byte(CHR_COMMA);
    add_field(vary(1));
    add_byte(CHR_COMMA);
    add_field(vary(2));
    add_tail();
  endtask

  task automatic fill_stimulus();
    int unsigned pick;
    bit          burst_done;
    burst_done = 1'b0;
    // directed: gsv with a dot in the satellite field, acknowledge at both byte
    // extremes, unknown header, end mark with no sentence, extreme idle bytes
    add_text("$GPGSV,,,9.*");
    add_ack(8'hFF);
    add_text("$GPGGB");
    add_byte(CHR_STAR);
    add_ack(8'h00);
    add_byte(8'h00);
    add_byte(8'hFF);
    while (rx_pending.size() < 1050) begin
      if (!burst_done && rx_pending.size() > 500) begin
        // drive both counters into saturation
        burst_done = 1'b1;
        add_text("$GPGGA");
        repeat (260) add_byte(CHR_COMMA);
        add_text("12");
        add_byte(CHR_STAR);
        add_ack(8'($urandom_range(0, 255)));
        repeat (260) add_byte(CHR_A);
      end
      pick = $urandom_range(0, 99);
      if (pick < 45) add_gga();
      else if (pick < 75) add_gsv();
      else if (pick < 85) begin
        add_header("GPRMC");
        add_tail();
      end else if (pick < 95) begin
        repeat ($urandom_range(1, 10)) add_byte(8'($urandom_range(0, 255)));
      end else add_ack(8'($urandom_range(0, 255)));
    end
  endtask

  // most gaps short, a few long
  function automatic int draw_len();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 88) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // ---- driver ----
  always @(negedge clk_i) begin
    if (rst_ni && (!in_valid_i || in_fire)) begin
      if (gap_left > 0) begin
        in_valid_i <= 1'b0;
        gap_left = gap_left - 1;
      end else if (rx_pending.size() > 0) begin
        in_valid_i <= 1'b1;
        in_data_i <= rx_pending.pop_front();
        if (in_calm > 0) begin
          in_calm = in_calm - 1;
          gap_left = 0;
        end else begin
          gap_left = draw_len();
          if ($urandom_range(0, 99) == 0) in_calm = $urandom_range(30, 150);
        end
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  // ---- receiver stalls ----
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (stall_left > 0) begin
        out_stall_i <= 1'b1;
        stall_left = stall_left - 1;
      end else begin
        out_stall_i <= 1'b0;
        if (out_calm > 0) out_calm = out_calm - 1;
        else begin
          stall_left = ($urandom_range(0, 2) == 0) ? draw_len() : 0;
          if ($urandom_range(0, 99) == 0) out_calm = $urandom_range(30, 150);
        end
      end
    end
  end

  // ---- monitor, checker and watchdog ----
  always @(posedge clk_i) begin
    in_fire <= rst_ni && in_valid_i && !in_stall_o;
    if (rst_ni && in_valid_i && !in_stall_o) begin
      parse_nmea_char(in_data_i, field_made, field_pred);
      if (field_made) fields_due.push_back(field_pred);
    end
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (fields_due.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS)
          $display("unexpected transfer: kind %0d value %h", out_data_o.field_kind,
                   out_data_o.field_value);
      end else begin
        field_want = fields_due.pop_front();
        if (out_data_o.field_kind !== field_want.field_kind ||
            out_data_o.field_value !== field_want.field_value ||
            out_data_o.fix_valid !== field_want.fix_valid ||
            out_data_o.signal_ok !== field_want.signal_ok ||
            out_data_o.sentence_mask !== field_want.sentence_mask ||
            out_data_o.position_hold !== field_want.position_hold) begin
          mismatches++;
          if (mismatches <= MAX_REPORTS) begin
            $display("mismatch: expected kind %0d value %h fix %b sig %b mask %b hold %b",
                     field_want.field_kind, field_want.field_value, field_want.fix_valid,
                     field_want.signal_ok, field_want.sentence_mask, field_want.position_hold);
            $display("          got      kind %0d value %h fix %b sig %b mask %b hold %b",
                     out_data_o.field_kind, out_data_o.field_value, out_data_o.fix_valid,
                     out_data_o.signal_ok, out_data_o.sentence_mask,
                     out_data_o.position_hold);
          end
        end
      end
    end
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) idle_cycles = 0;
    else idle_cycles++;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  initial begin
    psr_mode = MODE_IDLE;
    psr_stype = STYPE_NONE;
    fld_idx = '0;
    chr_idx = '0;
    fix_chr = '0;
    hold_flag = 1'b0;
    ended_mask = '0;
    signal_flag = 1'b0;
    foreach (hdr_chars[i]) hdr_chars[i] = '0;
    foreach (time_codes[i]) begin
      time_codes[i] = '0;
      lat_codes[i] = '0;
      lon_codes[i] = '0;
      used_codes[i] = '0;
      view_codes[i] = '0;
    end
    fill_stimulus();
    repeat (12) @(negedge clk_i);
    rst_ni <= 1'b1;
    while (rx_pending.size() != 0 || in_valid_i || fields_due.size() != 0)
      @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (mismatches == 0 && fields_due.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
